[design/key_matrix_lockout_debounce_defines.svh]
// Assertion macros for the key matrix lockout debouncer.
// Used by the top level only; needs no package.
`ifndef KEY_MATRIX_LOCKOUT_DEBOUNCE_DEFINES_SVH
`define KEY_MATRIX_LOCKOUT_DEBOUNCE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define KMLD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("kmld: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define KMLD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("kmld: next-cycle check failed");

`endif

[design/kmld_pkg.sv]
// Shared types and fixed widths of the key matrix lockout debouncer.
// No dependencies; imported by every module of the block.
`default_nettype none
package kmld_pkg;
    localparam int ROW_W     = 3;   // row number field
    localparam int DATA_W    = 16;  // raw and debounced column fields
    localparam int TMR_W     = 8;   // lockout timer and lockout setting
    localparam int ROW_EXT_W = 6;   // row number widened to compare with ROWS

    localparam logic [TMR_W-1:0] LOCKOUT_RST = 8'd5;

    // Port strobes of the row memory.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_mem_req;
endpackage
`default_nettype wire

[design/key_matrix_lockout_debounce.sv]
// Key matrix debouncer with per-key lockout. Each input beat is one scanned row
// (row number plus raw active-high column bits); each yields one output beat
// with that row's debounced bits. A key whose timer is nonzero counts down and
// ignores its raw bit; otherwise a raw change flips the key at once and loads
// the timer from the lockout setting. One beat is taken every cycle unless
// o_stall is high; an accepted beat passes the row-memory read, then the lane
// update, memory write-back and output register. A one-entry forwarding
// register covers a row scanned on two consecutive beats. Per-row valid flags
// clear the state at reset, so no clearing pass is needed. Rows at or beyond
// ROWS leave the state alone and report zero; columns at or beyond COLS
// report zero.
// Depends on kmld_pkg, kmld_row_mem, kmld_key_lanes and the defines header.
`default_nettype none
`include "key_matrix_lockout_debounce_defines.svh"
module key_matrix_lockout_debounce
    import kmld_pkg::*;
#(
    parameter int ROWS = 8,
    parameter int COLS = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [TMR_W-1:0]  i_cfg_wr_data,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [ROW_W-1:0]  i_row_index,
    input  wire logic [DATA_W-1:0] i_raw_pressed,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic      [ROW_W-1:0]  o_out_row,
    output logic      [DATA_W-1:0] o_debounced_row
);
    localparam int ADDR_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int ENTRY_W = COLS * (TMR_W + 1);

    logic [TMR_W-1:0] r_lockout_ticks;

    // Stage 1: memory read data arrives here
    logic              r_s1_vld;
    logic [ROW_W-1:0]  r_s1_row;
    logic [ADDR_W-1:0] r_s1_addr;
    logic              r_s1_inrange;
    logic [COLS-1:0]   r_s1_raw;

    // Last write-back, forwarded to a following beat of the same row
    logic               r_fw_vld;
    logic [ADDR_W-1:0]  r_fw_addr;
    logic [ENTRY_W-1:0] r_fw_data;

    logic              r_out_vld;
    logic [ROW_W-1:0]  r_out_row;
    logic [DATA_W-1:0] r_out_deb;
    logic [DATA_W-1:0] n_out_deb;

    logic [ROW_EXT_W-1:0] s_row_ext;
    logic [ADDR_W-1:0]    s_in_addr;
    logic                 s_in_range;
    logic [COLS-1:0]      s_raw_cols;
    logic                 s_accept;
    logic                 s_advance;
    t_mem_req             s_mem_req;
    logic [ENTRY_W-1:0]   s_rd_data;
    logic [ENTRY_W-1:0]   s_cur_entry;
    logic [ENTRY_W-1:0]   s_new_entry;

    assign s_row_ext  = {{(ROW_EXT_W-ROW_W){1'b0}}, i_row_index};
    assign s_in_addr  = s_row_ext[ADDR_W-1:0];
    assign s_in_range = (s_row_ext < ROW_EXT_W'(ROWS));

    for (genvar c = 0; c < COLS; c++) begin : g_raw
        if (c < DATA_W) begin : g_hit
            assign s_raw_cols[c] = i_raw_pressed[c];
        end else begin : g_pad
            assign s_raw_cols[c] = 1'b0;
        end
    end

    assign s_advance = !r_out_vld || !i_stall;
    assign o_stall   = r_s1_vld && !s_advance;
    assign s_accept  = i_valid && !o_stall;

    assign s_mem_req.rd_en = s_accept && s_in_range;
    assign s_mem_req.wr_en = r_s1_vld && s_advance && r_s1_inrange;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lockout_ticks <= LOCKOUT_RST;
        end else if (i_cfg_wr_en) begin
            r_lockout_ticks <= i_cfg_wr_data;
        end
    end

    kmld_row_mem #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_row_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (s_mem_req),
        .i_rd_addr (s_in_addr),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (s_new_entry),
        .o_rd_data (s_rd_data)
    );

    assign s_cur_entry = (r_fw_vld && (r_fw_addr == r_s1_addr)) ? r_fw_data : s_rd_data;

    kmld_key_lanes #(
        .COLS (COLS)
    ) u_key_lanes (
        .i_entry   (s_cur_entry),
        .i_raw     (r_s1_raw),
        .i_lockout (r_lockout_ticks),
        .o_entry   (s_new_entry)
    );

    for (genvar c = 0; c < DATA_W; c++) begin : g_out
        if (c < COLS) begin : g_hit
            assign n_out_deb[c] = r_s1_inrange && s_new_entry[c];
        end else begin : g_pad
            assign n_out_deb[c] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_fw_vld  <= 1'b0;
        end else begin
            if (s_accept) begin
                r_s1_vld <= 1'b1;
            end else if (s_advance) begin
                r_s1_vld <= 1'b0;
            end
            if (s_advance) begin
                r_out_vld <= r_s1_vld;
            end
            if (s_mem_req.wr_en) begin
                r_fw_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1_row     <= i_row_index;
            r_s1_addr    <= s_in_addr;
            r_s1_inrange <= s_in_range;
            r_s1_raw     <= s_raw_cols;
        end
        if (s_mem_req.wr_en) begin
            r_fw_addr <= r_s1_addr;
            r_fw_data <= s_new_entry;
        end
        if (s_advance && r_s1_vld) begin
            r_out_row <= r_s1_row;
            r_out_deb <= n_out_deb;
        end
    end

    assign o_valid         = r_out_vld;
    assign o_out_row       = r_out_row;
    assign o_debounced_row = r_out_deb;

    // Input is held back only when both stages are full and the output is blocked.
    `KMLD_ASSERT_IMP(a_stall_cause, i_clk, i_rst_n, o_stall,
        r_s1_vld && r_out_vld && i_stall)
    // An accepted beat always occupies stage 1 on the next cycle.
    `KMLD_ASSERT_NXT(a_accept_fills, i_clk, i_rst_n, s_accept, r_s1_vld)
    // Write-back only for a live, in-range row.
    `KMLD_ASSERT_IMP(a_write_legal, i_clk, i_rst_n, s_mem_req.wr_en,
        r_s1_vld && r_s1_inrange)
    // A beat leaving stage 1 shows up at the output with its row number.
    `KMLD_ASSERT_NXT(a_row_carried, i_clk, i_rst_n, r_s1_vld && s_advance,
        o_valid && (o_out_row == $past(r_s1_row)))
endmodule
`default_nettype wire

[design/kmld_row_mem.sv]
// Row memory: one entry per matrix row with debounced bits and lockout timers.
// Synchronous read with registered data; rows never written read as zero.
// Depends on kmld_pkg.
`default_nettype none
module kmld_row_mem
    import kmld_pkg::*;
#(
    parameter int ROWS = 8,
    parameter int COLS = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire t_mem_req                              i_req,
    input  wire logic [((ROWS > 1) ? $clog2(ROWS) : 1)-1:0] i_rd_addr,
    input  wire logic [((ROWS > 1) ? $clog2(ROWS) : 1)-1:0] i_wr_addr,
    input  wire logic [COLS*(TMR_W+1)-1:0]             i_wr_data,
    output logic      [COLS*(TMR_W+1)-1:0]             o_rd_data
);
    localparam int ENTRY_W = COLS * (TMR_W + 1);

    logic [ENTRY_W-1:0] r_mem [ROWS];
    logic [ROWS-1:0]    r_row_vld;
    logic [ENTRY_W-1:0] r_rd_data;
    logic               r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // Valid flags stand in for a clearing pass after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_row_vld[i_wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_vld <= r_row_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;
endmodule
`default_nettype wire

[design/kmld_key_lanes.sv]
// Per-key update lanes: lockout countdown or eager flip for each column.
// Purely combinational, one independent lane per column. Depends on kmld_pkg.
`default_nettype none
module kmld_key_lanes
    import kmld_pkg::*;
#(
    parameter int COLS = 16
) (
    input  wire logic [COLS*(TMR_W+1)-1:0] i_entry,
    input  wire logic [COLS-1:0]           i_raw,
    input  wire logic [TMR_W-1:0]          i_lockout,
    output logic      [COLS*(TMR_W+1)-1:0] o_entry
);
    // Entry layout: debounced bits in the low COLS bits, then one timer per column.
    always_comb begin
        logic [TMR_W-1:0] tmr;
        logic             deb;
        o_entry = i_entry;
        for (int c = 0; c < COLS; c++) begin
            tmr = i_entry[COLS + c*TMR_W +: TMR_W];
            deb = i_entry[c];
            if (tmr != '0) begin
                o_entry[COLS + c*TMR_W +: TMR_W] = tmr - 1'b1;
            end else if (deb != i_raw[c]) begin
                o_entry[c]                       = i_raw[c];
                o_entry[COLS + c*TMR_W +: TMR_W] = i_lockout;
            end
        end
    end
endmodule
`default_nettype wire
